### src/planar_arm_forward_kinematics_macros.svh
// Assertion macros for the planar arm forward kinematics block.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_MACROS_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_MACROS_SVH

// same-cycle implication, disabled during reset
`define PAFK_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PAFK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pafk_pkg.sv
// Package for the planar arm forward kinematics block: widths, types,
// register indexes and sine-series constants. No dependencies.
`timescale 1ns / 1ps
package pafk_pkg;

    localparam int ANGLE_W      = 16;
    localparam int LEN_W        = 16;
    localparam int POS_W        = 19;
    localparam int HEAD_W       = 18;
    localparam int TERM_W       = 18;
    localparam int ARG_W        = 15;
    localparam int SINE_W       = 15;
    localparam int JOINT_FIELDS = 4;
    localparam int MAX_JOINTS_DEFAULT = 4;
    localparam int CFG_ADDR_W   = 5;

    // quarter-wave sine pipeline: angle scale, square, 7 series terms, round
    localparam int TAYLOR_TERMS  = 7;
    localparam int QSINE_STAGES  = 2 + 3 * TAYLOR_TERMS + 1;
    localparam int LANE_STAGES   = QSINE_STAGES + 2;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam int RECIP_SHIFT   = 33;

    // register indexes (word address)
    localparam logic [2:0] REG_NUM_JOINTS = 3'd0;
    localparam logic [2:0] REG_LINK_LEN_0 = 3'd1;
    localparam logic [2:0] REG_LINK_LEN_1 = 3'd2;
    localparam logic [2:0] REG_LINK_LEN_2 = 3'd3;
    localparam logic [2:0] REG_LINK_LEN_3 = 3'd4;

    typedef logic [ANGLE_W-1:0]        phase_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic signed [TERM_W-1:0]  term_t;
    typedef logic signed [HEAD_W-1:0]  head_t;
    typedef logic signed [POS_W-1:0]   pos_t;

    // series divisor (2k)(2k+1) for term k
    function automatic int taylor_div(input int k);
        return (2 * k) * (2 * k + 1);
    endfunction

endpackage

### src/pafk_qsine.sv
// Pipelined quarter-wave sine: Q30 Taylor series, rounded to unsigned Q0.15.
// Depends on pafk_pkg.
`timescale 1ns / 1ps
module pafk_qsine
    import pafk_pkg::*;
(
    input  logic                    aclk,
    input  logic [QSINE_STAGES-1:0] en,
    input  logic [ARG_W-1:0]        r_in,
    output logic [SINE_W-1:0]       s_out
);

    logic [30:0]        theta_reg;
    logic [46:0]        theta_prod;
    logic [61:0]        theta_sq;
    logic [31:0]        t2_reg   [TAYLOR_TERMS+1];
    logic [30:0]        term_reg [TAYLOR_TERMS+1];
    logic signed [32:0] sum_reg  [TAYLOR_TERMS+1];
    logic signed [32:0] sum_rnd;
    logic [SINE_W-1:0]  s_reg;

    // angle in radians, Q30
    assign theta_prod = 47'(r_in) * 47'(PI_Q30);
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            theta_reg <= 31'((theta_prod + 47'(16384)) >> 15);
        end
    end

    // theta squared, first term
    assign theta_sq = 62'(theta_reg) * 62'(theta_reg);
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            t2_reg[0]   <= 32'(theta_sq >> 30);
            term_reg[0] <= theta_reg;
            sum_reg[0]  <= 33'(theta_reg);
        end
    end

    // one series term per three stages: multiply, reciprocal, correct
    for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_term
        localparam int          DIV   = taylor_div(j + 1);
        localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / 64'(DIV);

        logic [32:0]        va_reg;
        logic [31:0]        t2a_reg;
        logic signed [32:0] suma_reg;
        logic [30:0]        qb_reg;
        logic [32:0]        vb_reg;
        logic [31:0]        t2b_reg;
        logic signed [32:0] sumb_reg;
        logic [62:0]        mul_a;
        logic [63:0]        mul_b;
        logic [32:0]        qd;
        logic [32:0]        rem;
        logic [30:0]        q_fix;

        assign mul_a = 63'(term_reg[j]) * 63'(t2_reg[j]);
        always_ff @(posedge aclk) begin
            if (en[2+3*j]) begin
                va_reg   <= 33'(mul_a >> 30);
                t2a_reg  <= t2_reg[j];
                suma_reg <= sum_reg[j];
            end
        end

        // quotient estimate, at most one low
        assign mul_b = 64'(va_reg) * RECIP;
        always_ff @(posedge aclk) begin
            if (en[3+3*j]) begin
                qb_reg   <= 31'(mul_b >> RECIP_SHIFT);
                vb_reg   <= va_reg;
                t2b_reg  <= t2a_reg;
                sumb_reg <= suma_reg;
            end
        end

        assign qd    = 33'(qb_reg) * 33'(DIV);
        assign rem   = vb_reg - qd;
        assign q_fix = (rem >= 33'(DIV)) ? qb_reg + 31'd1 : qb_reg;
        always_ff @(posedge aclk) begin
            if (en[4+3*j]) begin
                term_reg[j+1] <= q_fix;
                t2_reg[j+1]   <= t2b_reg;
                // odd terms subtract
                if ((j % 2) == 0) begin
                    sum_reg[j+1] <= sumb_reg - $signed(33'(q_fix));
                end else begin
                    sum_reg[j+1] <= sumb_reg + $signed(33'(q_fix));
                end
            end
        end
    end

    // round to unsigned Q0.15, clamp at zero and full scale
    assign sum_rnd = (sum_reg[TAYLOR_TERMS] + 33'sd16384) >>> 15;
    always_ff @(posedge aclk) begin
        if (en[QSINE_STAGES-1]) begin
            if (sum_reg[TAYLOR_TERMS] <= 33'sd0) begin
                s_reg <= '0;
            end else if (sum_rnd > 33'sd32767) begin
                s_reg <= SINE_W'(32767);
            end else begin
                s_reg <= SINE_W'(sum_rnd);
            end
        end
    end

    assign s_out = s_reg;

endmodule

### src/pafk_lane.sv
// One joint lane: folds the running angle into a quarter wave, evaluates
// sine and cosine, scales by link length. Depends on pafk_pkg, pafk_qsine.
`timescale 1ns / 1ps
module pafk_lane
    import pafk_pkg::*;
(
    input  logic                   aclk,
    input  logic [LANE_STAGES-1:0] en,
    input  phase_t                 phase,
    input  len_t                   len,
    output term_t                  term_x,
    output term_t                  term_y
);

    logic [ARG_W-1:0]  arg_s_reg, arg_c_reg;
    logic              neg_s_reg, neg_c_reg;
    len_t              len_reg;
    logic              neg_s_d [QSINE_STAGES];
    logic              neg_c_d [QSINE_STAGES];
    len_t              len_d   [QSINE_STAGES];
    logic [SINE_W-1:0] sine, cosine;
    phase_t            cos_phase;
    logic [30:0]       prod_x, prod_y;
    logic [16:0]       rnd_x, rnd_y;
    term_t             term_x_reg, term_y_reg;

    // fold a phase into quarter-wave argument and sign
    function automatic logic [ARG_W:0] fold(input phase_t u);
        logic [ARG_W-1:0] arg;
        if (u[14]) begin
            arg = ARG_W'(16384) - {1'b0, u[13:0]};
        end else begin
            arg = {1'b0, u[13:0]};
        end
        return {u[15], arg};
    endfunction

    assign cos_phase = phase + phase_t'(16384);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            {neg_s_reg, arg_s_reg} <= fold(phase);
            {neg_c_reg, arg_c_reg} <= fold(cos_phase);
            len_reg                <= len;
        end
    end

    pafk_qsine u_sine (
        .aclk  (aclk),
        .en    (en[QSINE_STAGES:1]),
        .r_in  (arg_s_reg),
        .s_out (sine)
    );

    pafk_qsine u_cosine (
        .aclk  (aclk),
        .en    (en[QSINE_STAGES:1]),
        .r_in  (arg_c_reg),
        .s_out (cosine)
    );

    // sign and length ride along with the sine pipeline
    for (genvar i = 0; i < QSINE_STAGES; i++) begin : g_delay
        if (i == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en[1]) begin
                    neg_s_d[0] <= neg_s_reg;
                    neg_c_d[0] <= neg_c_reg;
                    len_d[0]   <= len_reg;
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en[i+1]) begin
                    neg_s_d[i] <= neg_s_d[i-1];
                    neg_c_d[i] <= neg_c_d[i-1];
                    len_d[i]   <= len_d[i-1];
                end
            end
        end
    end

    // length times trig, rounded half away from zero, then signed
    assign prod_x = 31'(len_d[QSINE_STAGES-1]) * 31'(cosine);
    assign prod_y = 31'(len_d[QSINE_STAGES-1]) * 31'(sine);
    assign rnd_x  = 17'((prod_x + 31'd16384) >> 15);
    assign rnd_y  = 17'((prod_y + 31'd16384) >> 15);

    always_ff @(posedge aclk) begin
        if (en[LANE_STAGES-1]) begin
            term_x_reg <= neg_c_d[QSINE_STAGES-1] ? -$signed(TERM_W'(rnd_x))
                                                 : $signed(TERM_W'(rnd_x));
            term_y_reg <= neg_s_d[QSINE_STAGES-1] ? -$signed(TERM_W'(rnd_y))
                                                 : $signed(TERM_W'(rnd_y));
        end
    end

    assign term_x = term_x_reg;
    assign term_y = term_y_reg;

endmodule

### src/pafk_merge.sv
// Merge stage: sums the lane terms into the tip position and registers
// the result with the heading. Depends on pafk_pkg.
`timescale 1ns / 1ps
module pafk_merge
    import pafk_pkg::*;
#(
    parameter int LANES = MAX_JOINTS_DEFAULT
) (
    input  logic  aclk,
    input  logic  en,
    input  term_t term_x [LANES],
    input  term_t term_y [LANES],
    input  head_t heading,
    output pos_t  tip_x,
    output pos_t  tip_y,
    output head_t tip_heading
);

    pos_t  sum_x, sum_y;
    pos_t  x_reg, y_reg;
    head_t head_reg;

    // adder over the lanes
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < LANES; i++) begin
            sum_x = sum_x + POS_W'(term_x[i]);
            sum_y = sum_y + POS_W'(term_y[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= sum_x;
            y_reg    <= sum_y;
            head_reg <= heading;
        end
    end

    assign tip_x       = x_reg;
    assign tip_y       = y_reg;
    assign tip_heading = head_reg;

endmodule

### src/planar_arm_forward_kinematics.sv
// Top level of the planar arm forward kinematics block: APB registers,
// input stage, joint lanes, merge and stage flow control.
// Depends on pafk_pkg, pafk_lane, pafk_merge and the assertion macros.
//
//  channel  direction  handshake        payload
//  s_       in         tvalid/tready    tdata[63:0] = joint_angle_0..3
//  m_       out        tvalid/tready    tdata[55:0] = tip_x, tip_y, tip_heading
//  apb      in         psel/penable     5 registers at 4*i
//
// One pose enters per cycle while the output is not stalled; the pipeline is the 24-stage
// sine series pipeline in each lane plus input, fold, scaling and merge stages.
// Every stage holds a valid bit; a stage loads when it or any stage after
// it is empty, so bubbles collapse and input is taken while a result waits.
// Reset (aresetn low, synchronous) empties the pipeline and sets
// num_joints to 1 and all link lengths to 0.
`timescale 1ns / 1ps
`include "planar_arm_forward_kinematics_macros.svh"
module planar_arm_forward_kinematics
    import pafk_pkg::*;
#(
    parameter int MAX_JOINTS = MAX_JOINTS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // joint_angle_0 [15:0], joint_angle_1 [31:16], joint_angle_2 [47:32],
    // joint_angle_3 [63:48]
    input  logic [63:0]           s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tip_x [18:0], tip_y [37:19], tip_heading [55:38]
    output logic [55:0]           m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int LANES = (MAX_JOINTS < JOINT_FIELDS) ? MAX_JOINTS : JOINT_FIELDS;
    localparam int NST   = LANE_STAGES + 2;

    logic [2:0]     num_joints_reg;
    len_t           link_len_reg [JOINT_FIELDS];
    logic [2:0]     reg_idx;
    logic           cfg_write;
    logic [NST-1:0] stage_valid_reg;
    logic [NST-1:0] en;
    logic [2:0]     n_eff;
    phase_t         phase_next [LANES];
    len_t           len_next   [LANES];
    head_t          head_next;
    phase_t         phase_reg  [LANES];
    len_t           len_reg    [LANES];
    head_t          head_d     [LANE_STAGES+1];
    term_t          term_x     [LANES];
    term_t          term_y     [LANES];
    pos_t           tip_x, tip_y;
    head_t          tip_heading;

    // register port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_joints_reg <= 3'd1;
            for (int i = 0; i < JOINT_FIELDS; i++) begin
                link_len_reg[i] <= '0;
            end
        end else if (cfg_write) begin
            case (reg_idx)
                REG_NUM_JOINTS: num_joints_reg  <= pwdata[2:0];
                REG_LINK_LEN_0: link_len_reg[0] <= pwdata[15:0];
                REG_LINK_LEN_1: link_len_reg[1] <= pwdata[15:0];
                REG_LINK_LEN_2: link_len_reg[2] <= pwdata[15:0];
                REG_LINK_LEN_3: link_len_reg[3] <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NUM_JOINTS: prdata = {29'd0, num_joints_reg};
            REG_LINK_LEN_0: prdata = {16'd0, link_len_reg[0]};
            REG_LINK_LEN_1: prdata = {16'd0, link_len_reg[1]};
            REG_LINK_LEN_2: prdata = {16'd0, link_len_reg[2]};
            REG_LINK_LEN_3: prdata = {16'd0, link_len_reg[3]};
            default:        prdata = '0;
        endcase
    end

    // stage loads when some stage at or after it is empty, or output drains
    always_comb begin
        for (int i = 0; i < NST; i++) begin
            en[i] = m_tready || !(&(stage_valid_reg | ((NST'(1) << i) - NST'(1))));
        end
    end
    assign s_tready = en[0];
    assign m_tvalid = stage_valid_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            if (en[0]) begin
                stage_valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    stage_valid_reg[i] <= stage_valid_reg[i-1];
                end
            end
        end
    end

    // running angles, masked lengths and heading
    assign n_eff = (num_joints_reg > 3'(LANES)) ? 3'(LANES) : num_joints_reg;

    always_comb begin
        phase_t acc;
        acc       = '0;
        head_next = '0;
        for (int i = 0; i < LANES; i++) begin
            acc           = acc + s_tdata[16*i +: 16];
            phase_next[i] = acc;
            len_next[i]   = (3'(i) < n_eff) ? link_len_reg[i] : '0;
            if (3'(i) < n_eff) begin
                head_next = head_next + HEAD_W'($signed(s_tdata[16*i +: 16]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            head_d[0] <= head_next;
        end
    end

    // heading waits out the lane latency
    for (genvar i = 1; i <= LANE_STAGES; i++) begin : g_head
        always_ff @(posedge aclk) begin
            if (en[i]) begin
                head_d[i] <= head_d[i-1];
            end
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        pafk_lane u_lane (
            .aclk   (aclk),
            .en     (en[LANE_STAGES:1]),
            .phase  (phase_reg[k]),
            .len    (len_reg[k]),
            .term_x (term_x[k]),
            .term_y (term_y[k])
        );
    end

    pafk_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk        (aclk),
        .en          (en[NST-1]),
        .term_x      (term_x),
        .term_y      (term_y),
        .heading     (head_d[LANE_STAGES]),
        .tip_x       (tip_x),
        .tip_y       (tip_y),
        .tip_heading (tip_heading)
    );

    assign m_tdata = {tip_heading, tip_y, tip_x};

    // checks
    `PAFK_ASSERT_IMPL(a_ready_when_drained, !m_tvalid, s_tready, "input stalled with empty output")
    `PAFK_ASSERT_NEXT(a_request_enters, s_tvalid && s_tready, stage_valid_reg[0], "request lost at entry")
    `PAFK_ASSERT_IMPL(a_result_has_source, $rose(m_tvalid), $past(stage_valid_reg[NST-2]), "result without source")

endmodule

### bench/planar_arm_forward_kinematics_tb.sv
// Self-checking bench for planar_arm_forward_kinematics: drives poses on the
// s_ stream, programs the APB registers, predicts each tip result and checks m_.
// Depends on pafk_pkg and the block's RTL.
`timescale 1ns / 1ps
module planar_arm_forward_kinematics_tb;
    import pafk_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLDOFF_CYCLES = 300;
    localparam longint unsigned PI_Q30_L = 64'd3373259426;

    typedef struct packed {
        head_t heading;
        pos_t  y;
        pos_t  x;
    } tip_t;

    logic                  aclk;
    logic                  aresetn;
    logic [63:0]           s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [55:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // bench copy of the register file
    logic [2:0]  joints_reg;
    logic [15:0] link_reg [4];

    tip_t tip_queue [$];
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   holdoff_req;
    int   holdoff_left;
    int   idle_count;
    int   error_count;
    int   pose_count;
    int   tip_count;

    planar_arm_forward_kinematics DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // sine of a quarter-wave offset (0..16384), Q1.15, Taylor series in Q30
    function automatic int quarter_sin(input int unsigned r);
        longint unsigned th, t2, term;
        longint          acc, v;
        th   = (longint'(r) * PI_Q30_L + 64'd16384) >> 15;
        t2   = (th * th) >> 30;
        term = th;
        acc  = longint'(th);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - longint'(term);
            else            acc = acc + longint'(term);
        end
        if (acc <= 0) return 0;
        v = (acc + 16384) >>> 15;
        if (v > 32767) v = 32767;
        return int'(v);
    endfunction

    function automatic int angle_sin(input logic [15:0] u);
        int s;
        if (u[14]) s = quarter_sin(16384 - u[13:0]);
        else       s = quarter_sin(u[13:0]);
        return u[15] ? -s : s;
    endfunction

    // length times trig, rounded to Q8.8, ties away from zero
    function automatic longint link_term(input logic [15:0] len, input int trig);
        longint p, mag, r;
        p   = longint'(len) * longint'(trig);
        mag = (p < 0) ? -p : p;
        r   = (mag + 16384) >>> 15;
        return (p < 0) ? -r : r;
    endfunction

    function automatic tip_t predict_tip(input logic [63:0] d);
        tip_t        t;
        int          n, heading;
        logic [15:0] phase, ang;
        longint      x, y;
        n       = (joints_reg > 3'd4) ? 4 : int'(joints_reg);
        phase   = '0;
        heading = 0;
        x       = 0;
        y       = 0;
        for (int i = 0; i < n; i++) begin
            ang     = d[16*i +: 16];
            heading = heading + int'($signed(ang));
            phase   = phase + ang;
            x = x + link_term(link_reg[i], angle_sin(phase + 16'd16384));
            y = y + link_term(link_reg[i], angle_sin(phase));
        end
        t.x       = pos_t'(x);
        t.y       = pos_t'(y);
        t.heading = head_t'(heading);
        return t;
    endfunction

    // APB write: setup then access, pready is always high; the bus is
    // released by the caller after its last write
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (idx == REG_NUM_JOINTS) joints_reg = value[2:0];
        else link_reg[idx - 1] = value[15:0];
    endtask

    task automatic set_arm(input logic [2:0] n, input logic [15:0] l0, input logic [15:0] l1,
                           input logic [15:0] l2, input logic [15:0] l3);
        reg_write(REG_NUM_JOINTS, 32'(n));
        reg_write(REG_LINK_LEN_0, 32'(l0));
        reg_write(REG_LINK_LEN_1, 32'(l1));
        reg_write(REG_LINK_LEN_2, 32'(l2));
        reg_write(REG_LINK_LEN_3, 32'(l3));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, wait for every outstanding tip, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tip_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one pose request; the expectation is queued when it is accepted
    task automatic send_pose(input logic [63:0] d);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        taken = 0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end
        tip_queue.push_back(predict_tip(d));
        pose_count++;
    endtask

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(16'h4000 * $urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_len();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic [15:0] pick [8];
        pick = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h2000};
        set_arm(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_pose({pick[i], pick[i], pick[i], pick[i]});
        send_pose({16'h8000, 16'h8000, 16'h8000, 16'h8000});
        send_pose({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        drain();
        // zero to three joints, then counts past the four available fields
        for (int n = 0; n < 8; n++) begin
            if (n != 4) begin
                set_arm(3'(n), 16'h0100, 16'hFFFF, 16'h0080, 16'h1234);
                send_pose({16'h1111, 16'h9000, 16'h7FFF, 16'h4000});
                send_pose(64'hFFFF_8000_0001_C000);
                drain();
            end
        end
        // unused angle fields must not matter
        set_arm(3'd2, 16'h0200, 16'h0300, 16'hFFFF, 16'hFFFF);
        send_pose(64'h0000_0000_2000_1000);
        send_pose(64'hFFFF_7FFF_2000_1000);
        drain();
    endtask

    task automatic test_random(input int sidle, input int rstall, input int poses);
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        for (int blk = 0; blk < 4; blk++) begin
            set_arm(3'($urandom_range(1, 4)), rand_len(), rand_len(), rand_len(), rand_len());
            for (int i = 0; i < poses / 4; i++)
                send_pose({rand_angle(), rand_angle(), rand_angle(), rand_angle()});
            drain();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_arm(3'd4, rand_len(), rand_len(), rand_len(), rand_len());
        holdoff_req = 1;
        for (int i = 0; i < 80; i++)
            send_pose({16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)});
        drain();
    endtask

    // receiver: random stall, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holdoff_req) begin
            holdoff_req  = 0;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check and watchdog, sampled mid-cycle
    always @(negedge aclk) begin
        tip_t got, want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_count = 0;
            else idle_count = idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d tips outstanding", $realtime,
                         tip_queue.size());
                $display("planar_arm_forward_kinematics_tb: FAIL");
                $finish;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                tip_count++;
                if (tip_queue.size() == 0) begin
                    $display("%0t: unexpected tip, actual %h", $realtime, m_tdata);
                    error_count++;
                end else begin
                    want = tip_queue.pop_front();
                    if (got.x !== want.x) begin
                        $display("%0t: tip_x expected %0d actual %0d", $realtime,
                                 want.x, got.x);
                        error_count++;
                    end
                    if (got.y !== want.y) begin
                        $display("%0t: tip_y expected %0d actual %0d", $realtime,
                                 want.y, got.y);
                        error_count++;
                    end
                    if (got.heading !== want.heading) begin
                        $display("%0t: tip_heading expected %0d actual %0d", $realtime,
                                 want.heading, got.heading);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tdata        = '0;
        s_tvalid       = 1'b0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 0;
        holdoff_left   = 0;
        idle_count     = 0;
        error_count    = 0;
        pose_count     = 0;
        tip_count      = 0;
        joints_reg     = 3'd1;
        for (int i = 0; i < 4; i++) link_reg[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(0, 0, 460);
        test_random(63, 0, 440);
        test_random(0, 63, 440);
        test_random(22, 22, 440);
        test_backpressure();

        drain();
        $display("Covered %0d poses / %0d tips: 0..7 joints, extreme lengths and angles,",
                 pose_count, tip_count);
        $display("sender gaps, receiver stalls and a long output hold-off.");
        if (error_count == 0 && tip_queue.size() == 0)
            $display("planar_arm_forward_kinematics_tb: PASS");
        else
            $display("planar_arm_forward_kinematics_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/pafk_pkg.sv
src/pafk_qsine.sv
src/pafk_lane.sv
src/pafk_merge.sv
src/planar_arm_forward_kinematics.sv
bench/planar_arm_forward_kinematics_tb.sv
